// ===== hdl/cpu_alu_with_flags_defines.svh =====
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_defines.svh
// Assertion macros for the 8-bit ALU. Every check is clocked on clk and
// held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define CALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define CALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/calu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_pkg
// Operation codes, flag positions and transfer structs for the 8-bit ALU.
// ----------------------------------------------------------------------------
package calu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    ACT_ADD    = 5'd0,
    ACT_ADC    = 5'd1,
    ACT_AND    = 5'd2,
    ACT_OR     = 5'd3,
    ACT_XOR    = 5'd4,
    ACT_CP     = 5'd5,
    ACT_INC8   = 5'd6,
    ACT_DEC8   = 5'd7,
    ACT_SWAP   = 5'd8,
    ACT_RLC    = 5'd9,
    ACT_RLCA   = 5'd10,
    ACT_RES    = 5'd11,
    ACT_SET    = 5'd12,
    ACT_BIT    = 5'd13,
    ACT_CCF    = 5'd14,
    ACT_CPL    = 5'd15,
    ACT_INC16  = 5'd16,
    ACT_DEC16  = 5'd17,
    ACT_SP_OFS = 5'd18
  } calu_action_t;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    calu_action_t action;
    logic [15:0]  operand_x;
    logic [7:0]   operand_y;
    logic [2:0]   bit_index;
    logic [3:0]   flags_in;
  } calu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_back;
  } calu_out_t;

  // Packs Z/N/H/C into the flag nibble
  function automatic logic [3:0] mk_flags(input logic z, input logic n,
                                          input logic h, input logic c);
    logic [3:0] f;
    f         = 4'b0000;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

endpackage

// ===== hdl/calu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_core
// Combinational datapath: computes result, flags and write-back mark for one
// registered operation.
// ----------------------------------------------------------------------------
module calu_core (
  input  calu_pkg::calu_in_t  op_i,
  output calu_pkg::calu_out_t res_o
);
  import calu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  y;
  logic [3:0]  fi;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  half5;
  logic [8:0]  diff9;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  bmask;
  logic [15:0] inc16;
  logic [15:0] dec16;
  logic [15:0] sp_sum;

  // Shared arithmetic
  assign a      = op_i.operand_x[7:0];
  assign y      = op_i.operand_y;
  assign fi     = op_i.flags_in;
  assign cin    = (op_i.action == ACT_ADC) ? fi[FLAG_C] : 1'b0;
  assign sum9   = {1'b0, a} + {1'b0, y} + {8'd0, cin};
  assign half5  = {1'b0, a[3:0]} + {1'b0, y[3:0]} + {4'd0, cin};
  assign diff9  = {1'b0, a} - {1'b0, y};
  assign inc8   = a + 8'd1;
  assign dec8   = a - 8'd1;
  assign bmask  = 8'd1 << op_i.bit_index;
  assign inc16  = op_i.operand_x + 16'd1;
  assign dec16  = op_i.operand_x - 16'd1;
  assign sp_sum = op_i.operand_x + {{8{y[7]}}, y};

  // Operation select
  always_comb begin
    logic [7:0] r8;
    r8               = 8'd0;
    res_o.result     = op_i.operand_x;
    res_o.flags_out  = fi;
    res_o.write_back = 1'b1;
    unique case (op_i.action) inside
      ACT_ADD, ACT_ADC: begin
        r8              = sum9[7:0];
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, half5[4], sum9[8]);
      end
      ACT_AND: begin
        r8              = a & y;
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, 1'b1, 1'b0);
      end
      ACT_OR: begin
        r8              = a | y;
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, 1'b0, 1'b0);
      end
      ACT_XOR: begin
        r8              = a ^ y;
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, 1'b0, 1'b0);
      end
      ACT_CP: begin
        res_o.write_back = 1'b0;
        res_o.flags_out  = mk_flags(diff9[7:0] == 8'd0, 1'b1,
                                    a[3:0] < y[3:0], diff9[8]);
      end
      ACT_INC8: begin
        res_o.result    = {8'd0, inc8};
        res_o.flags_out = mk_flags(inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, fi[FLAG_C]);
      end
      ACT_DEC8: begin
        res_o.result    = {8'd0, dec8};
        res_o.flags_out = mk_flags(dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, fi[FLAG_C]);
      end
      ACT_SWAP: begin
        r8              = {a[3:0], a[7:4]};
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, 1'b0, 1'b0);
      end
      ACT_RLC: begin
        r8              = {a[6:0], a[7]};
        res_o.result    = {8'd0, r8};
        res_o.flags_out = mk_flags(r8 == 8'd0, 1'b0, 1'b0, a[7]);
      end
      ACT_RLCA: begin
        res_o.result    = {8'd0, a[6:0], a[7]};
        res_o.flags_out = mk_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      ACT_RES: res_o.result = {8'd0, a & ~bmask};
      ACT_SET: res_o.result = {8'd0, a | bmask};
      ACT_BIT: begin
        res_o.write_back = 1'b0;
        res_o.flags_out  = mk_flags((a & bmask) == 8'd0, 1'b0, 1'b1, fi[FLAG_C]);
      end
      ACT_CCF: begin
        res_o.write_back = 1'b0;
        res_o.flags_out  = mk_flags(fi[FLAG_Z], 1'b0, 1'b0, ~fi[FLAG_C]);
      end
      ACT_CPL: begin
        res_o.result    = {8'd0, ~a};
        res_o.flags_out = mk_flags(fi[FLAG_Z], 1'b1, 1'b1, fi[FLAG_C]);
      end
      ACT_INC16: res_o.result = inc16;
      ACT_DEC16: res_o.result = dec16;
      // cin is zero here, so sum9/half5 are the plain low-byte carries
      ACT_SP_OFS: begin
        res_o.result    = sp_sum;
        res_o.flags_out = mk_flags(1'b0, 1'b0, half5[4], sum9[8]);
      end
      default: res_o.write_back = 1'b0;
    endcase
  end

endmodule

// ===== hdl/cpu_alu_with_flags.sv =====
`timescale 1ns / 1ps
`include "cpu_alu_with_flags_defines.svh"
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit ALU with Z/N/H/C flags, input register -> datapath -> result register.
// ----------------------------------------------------------------------------
// An operation is taken on every clock edge with start high (busy is always
// low), so one operation per cycle is sustained. Its result passes through the
// input register and the result register around the combinational datapath
// and appears on out_item with out_valid high for exactly one cycle. The
// receiver cannot stall: a result not captured in its strobe cycle is gone.
module cpu_alu_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  calu_pkg::calu_in_t  in_item,
  output logic                out_valid,
  output calu_pkg::calu_out_t out_item
);
  import calu_pkg::*;

  logic      in_valid_r;
  calu_in_t  in_r;
  calu_out_t core_res;
  logic      out_valid_r;
  calu_out_t out_r;
  logic      no_wb_op;
  logic      keeps_flags_op;

  // Never stalls the issuing side
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_item;
    end
  end

  // Datapath
  calu_core u_core (
    .op_i  (in_r),
    .res_o (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Operation classes used by the checks
  assign no_wb_op       = in_r.action inside {ACT_CP, ACT_BIT, ACT_CCF};
  assign keeps_flags_op = in_r.action inside {ACT_RES, ACT_SET, ACT_INC16, ACT_DEC16};

  // Checks
  `CALU_ASSERT_NOW(a_result_follows, start && !busy, ##2 out_valid, "lost result")
  `CALU_ASSERT_NOW(a_no_spurious, !start, ##2 !out_valid, "result without transfer")
  `CALU_ASSERT_NEXT(a_no_wb_compare, in_valid_r && no_wb_op, !out_item.write_back, "write-back on test")
  `CALU_ASSERT_NEXT(a_flags_kept, in_valid_r && keeps_flags_op, out_item.flags_out == $past(in_r.flags_in), "flags changed")

endmodule

// ===== bench/cpu_alu_with_flags_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_test
// Self-checking bench for the 8-bit ALU with Z/N/H/C flags. A short table of
// hand-picked operations, some with their expected outcome written in, is
// followed by random operations. Every accepted operation without a written-in
// outcome is run through a behavioral model of the ALU, and every result
// strobe is checked field by field against the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_test;
  import calu_pkg::*;

  localparam int unsigned RANDOM_OPS  = 1550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // One row of the directed table; pinned rows carry their outcome
  typedef struct {
    calu_in_t  op;
    bit        pinned;
    calu_out_t want;
  } vector_row_t;

  logic      clk;
  logic      rst_n       = 1'b0;
  logic      start       = 1'b0;
  calu_in_t  in_item     = '0;
  logic      busy;
  logic      out_valid;
  calu_out_t out_item;

  // Travels alongside in_item so the checker sees it at the accepting edge
  logic      pinned_on   = 1'b0;
  calu_out_t pinned_want = '0;

  calu_out_t   outcome_q[$];
  vector_row_t op_table[$];

  int unsigned err_count     = 0;
  int unsigned ops_accepted  = 0;
  int unsigned results_seen  = 0;
  int unsigned undefined_ops = 0;
  int unsigned stall_cycles  = 0;

  cpu_alu_with_flags uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Behavioral model of one ALU operation
  function automatic calu_out_t alu_outcome(input calu_in_t op);
    logic [7:0] a;
    logic [7:0] y;
    logic [3:0] fi;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] nib;
    logic [7:0] r8;
    calu_out_t  r;
    a            = op.operand_x[7:0];
    y            = op.operand_y;
    fi           = op.flags_in;
    r.result     = op.operand_x;
    r.flags_out  = fi;
    r.write_back = 1'b1;
    case (op.action) inside
      ACT_ADD, ACT_ADC: begin
        cin         = (op.action == ACT_ADC) ? fi[FLAG_C] : 1'b0;
        sum9        = {1'b0, a} + {1'b0, y} + {8'h00, cin};
        nib         = {1'b0, a[3:0]} + {1'b0, y[3:0]} + {4'h0, cin};
        r.result    = {8'h00, sum9[7:0]};
        r.flags_out = {sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      ACT_AND: begin
        r8          = a & y;
        r.result    = {8'h00, r8};
        r.flags_out = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      ACT_OR, ACT_XOR, ACT_SWAP: begin
        if (op.action == ACT_OR) r8 = a | y;
        else if (op.action == ACT_XOR) r8 = a ^ y;
        else r8 = {a[3:0], a[7:4]};
        r.result    = {8'h00, r8};
        r.flags_out = {r8 == 8'h00, 3'b000};
      end
      ACT_CP: begin
        // compare only: value untouched, borrow flags
        r.write_back = 1'b0;
        r.flags_out  = {a == y, 1'b1, a[3:0] < y[3:0], a < y};
      end
      ACT_INC8: begin
        r8          = a + 8'h01;
        r.result    = {8'h00, r8};
        r.flags_out = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, fi[FLAG_C]};
      end
      ACT_DEC8: begin
        r8          = a - 8'h01;
        r.result    = {8'h00, r8};
        r.flags_out = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, fi[FLAG_C]};
      end
      ACT_RLC, ACT_RLCA: begin
        // rlca never sets Z
        r8          = {a[6:0], a[7]};
        r.result    = {8'h00, r8};
        r.flags_out = {(op.action == ACT_RLC) && (r8 == 8'h00), 2'b00, a[7]};
      end
      ACT_RES:   r.result = {8'h00, a & ~(8'h01 << op.bit_index)};
      ACT_SET:   r.result = {8'h00, a | (8'h01 << op.bit_index)};
      ACT_BIT: begin
        r.write_back = 1'b0;
        r.flags_out  = {~a[op.bit_index], 1'b0, 1'b1, fi[FLAG_C]};
      end
      ACT_CCF: begin
        r.write_back = 1'b0;
        r.flags_out  = {fi[FLAG_Z], 2'b00, ~fi[FLAG_C]};
      end
      ACT_CPL: begin
        r.result    = {8'h00, ~a};
        r.flags_out = {fi[FLAG_Z], 1'b1, 1'b1, fi[FLAG_C]};
      end
      ACT_INC16: r.result = op.operand_x + 16'h0001;
      ACT_DEC16: r.result = op.operand_x - 16'h0001;
      ACT_SP_OFS: begin
        // signed offset; H and C from the unsigned low-byte add
        sum9        = {1'b0, a} + {1'b0, y};
        nib         = {1'b0, a[3:0]} + {1'b0, y[3:0]};
        r.result    = op.operand_x + {{8{y[7]}}, y};
        r.flags_out = {2'b00, nib[4], sum9[8]};
      end
      default:   r.write_back = 1'b0;
    endcase
    return r;
  endfunction

  function automatic calu_in_t make_op(input logic [4:0] act, input logic [15:0] x,
                                       input logic [7:0] y, input logic [2:0] bi,
                                       input logic [3:0] f);
    calu_in_t op;
    op.action    = calu_action_t'(act);
    op.operand_x = x;
    op.operand_y = y;
    op.bit_index = bi;
    op.flags_in  = f;
    return op;
  endfunction

  task automatic add_row(input calu_in_t op, input bit pinned, input logic [15:0] res,
                         input logic [3:0] flags, input logic wb);
    vector_row_t row;
    row.op              = op;
    row.pinned          = pinned;
    row.want.result     = res;
    row.want.flags_out  = flags;
    row.want.write_back = wb;
    op_table.push_back(row);
  endtask

  // Operand values biased toward carry and nibble corners
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom) | 16'h000F;
      3:       return 16'($urandom) & 16'hFFF0;
      4:       return 16'($urandom) & 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Checker and watchdog: results first, then the transfer on the input side
  always @(posedge clk) begin
    calu_out_t   want;
    int unsigned bad;
    bad = 0;
    if (rst_n) begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          $error("result strobe with no operation outstanding");
          bad++;
        end else begin
          want = outcome_q.pop_front();
          if (out_item.result !== want.result) begin
            $error("result: expected %h, got %h", want.result, out_item.result);
            bad++;
          end
          if (out_item.flags_out !== want.flags_out) begin
            $error("flags_out: expected %b, got %b", want.flags_out, out_item.flags_out);
            bad++;
          end
          if (out_item.write_back !== want.write_back) begin
            $error("write_back: expected %b, got %b", want.write_back,
                   out_item.write_back);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        ops_accepted <= ops_accepted + 1;
        outcome_q.push_back(pinned_on ? pinned_want : alu_outcome(in_item));
      end
      if (out_valid || (start && !busy)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (bad != 0) begin
        err_count <= err_count + bad;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, outcome_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    calu_in_t    op;
    logic [15:0] w;
    logic [35:0] junk;
    int unsigned gap;
    int unsigned total;
    bit          burst;

    // directed table: extremes, every op code, wraps and undefined codes
    add_row(make_op(ACT_ADD,   16'h00FF, 8'h01, 3'd0, 4'h0), 1, 16'h0000, 4'b1011, 1);
    add_row(make_op(ACT_ADD,   16'hFF00, 8'h00, 3'd7, 4'hF), 1, 16'h0000, 4'b1000, 1);
    add_row(make_op(ACT_ADC,   16'h000F, 8'h00, 3'd0, 4'h1), 0, '0, '0, 0);
    add_row(make_op(ACT_ADC,   16'hFFFF, 8'hFF, 3'd0, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_AND,   16'h00F0, 8'h0F, 3'd0, 4'h0), 1, 16'h0000, 4'b1010, 1);
    add_row(make_op(ACT_OR,    16'hFFFF, 8'hFF, 3'd7, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_XOR,   16'h00AA, 8'hAA, 3'd0, 4'h7), 1, 16'h0000, 4'b1000, 1);
    add_row(make_op(ACT_CP,    16'h0034, 8'h35, 3'd0, 4'h0), 0, '0, '0, 0);
    add_row(make_op(ACT_CP,    16'h1212, 8'h12, 3'd0, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_INC8,  16'h00FF, 8'h00, 3'd0, 4'h1), 1, 16'h0000, 4'b1011, 1);
    add_row(make_op(ACT_DEC8,  16'h0000, 8'h00, 3'd0, 4'h0), 1, 16'h00FF, 4'b0110, 1);
    add_row(make_op(ACT_SWAP,  16'hA5F1, 8'h00, 3'd0, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_RLC,   16'h0080, 8'h00, 3'd0, 4'h0), 0, '0, '0, 0);
    add_row(make_op(ACT_RLCA,  16'h0000, 8'h00, 3'd0, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_RES,   16'hFFFF, 8'h00, 3'd7, 4'h5), 0, '0, '0, 0);
    add_row(make_op(ACT_SET,   16'h0000, 8'h00, 3'd0, 4'hA), 0, '0, '0, 0);
    add_row(make_op(ACT_BIT,   16'h007F, 8'h00, 3'd7, 4'h1), 0, '0, '0, 0);
    add_row(make_op(ACT_CCF,   16'h0000, 8'h00, 3'd0, 4'h9), 0, '0, '0, 0);
    add_row(make_op(ACT_CPL,   16'h0000, 8'h00, 3'd0, 4'h0), 0, '0, '0, 0);
    add_row(make_op(ACT_INC16, 16'hFFFF, 8'h00, 3'd0, 4'h5), 1, 16'h0000, 4'h5, 1);
    add_row(make_op(ACT_DEC16, 16'h0000, 8'h00, 3'd0, 4'hA), 1, 16'hFFFF, 4'hA, 1);
    add_row(make_op(ACT_SP_OFS, 16'hFFFF, 8'h01, 3'd0, 4'hF), 0, '0, '0, 0);
    add_row(make_op(ACT_SP_OFS, 16'h0000, 8'h80, 3'd0, 4'h0), 0, '0, '0, 0);
    add_row(make_op(5'd19, 16'h1234, 8'hFF, 3'd7, 4'hF), 1, 16'h1234, 4'hF, 0);
    add_row(make_op(5'd31, 16'hFFFF, 8'h00, 3'd0, 4'h0), 1, 16'hFFFF, 4'h0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    total = op_table.size() + RANDOM_OPS;
    burst = 1'b0;
    for (int unsigned i = 0; i < total; i++) begin
      if (i < op_table.size()) begin
        op = op_table[i].op;
        pinned_on   <= op_table[i].pinned;
        pinned_want <= op_table[i].want;
      end else begin
        // mostly defined op codes, a few undefined ones
        if ($urandom_range(0, 9) == 0) begin
          op.action = calu_action_t'(5'($urandom_range(19, 31)));
          undefined_ops++;
        end else begin
          op.action = calu_action_t'(5'($urandom_range(0, 18)));
        end
        op.operand_x = pick_word();
        w            = pick_word();
        op.operand_y = w[7:0];
        op.bit_index = 3'($urandom);
        op.flags_in  = 4'($urandom);
        pinned_on   <= 1'b0;
      end
      start   <= 1'b1;
      in_item <= op;
      @(posedge clk);
      while (busy) @(posedge clk);

      // switch between back-to-back bursts and gapped stretches
      if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        junk = 36'({$urandom, $urandom});
        start     <= 1'b0;
        in_item   <= junk;
        pinned_on <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // drain: wait for every outstanding result, then idle before the summary
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d operations (%0d from the table, %0d on undefined codes),",
             ops_accepted, op_table.size(), undefined_ops);
    $display("%0d results checked, with random idle gaps of 0 to 16 cycles", results_seen);
    $display("between transfers and back-to-back bursts");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
